[hw/rtl/random_n_of_n_packet_sampler_top_defines.svh]
// Assertion macros shared by the packet sampler RTL.
`ifndef RANDOM_N_OF_N_PACKET_SAMPLER_TOP_DEFINES_SVH
`define RANDOM_N_OF_N_PACKET_SAMPLER_TOP_DEFINES_SVH

// Checks that a condition implies a consequence in the same cycle.
`define RNNS_ASSERT_SAME(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("rnns: same-cycle check failed");

// Checks that a condition implies a consequence in the following cycle.
`define RNNS_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("rnns: next-cycle check failed");

`endif

[hw/rtl/rnns_pkg.sv]
// Types, constants and helper functions of the packet sampler.
package rnns_pkg;

    localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_TYPE_ARP  = 16'h0806;
    localparam logic [15:0] ETH_TYPE_VLAN = 16'h8100;

    localparam logic [15:0] ETH_HDR_LEN  = 16'd14;
    localparam logic [15:0] VLAN_TAG_LEN = 16'd4;
    localparam logic [15:0] TCP_MIN_LEN  = 16'd13;
    localparam logic [15:0] UDP_HDR_LEN  = 16'd8;
    localparam logic [15:0] ICMP_HDR_LEN = 16'd8;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PICKS  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SEED   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_QUAL,
        ST_COUNT,
        ST_CMP,
        ST_GEN,
        ST_DIV,
        ST_DUP_RD,
        ST_DUP_CMP,
        ST_INS_RD,
        ST_INS_CMP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    function automatic logic [31:0] xorshift32(input logic [31:0] x);
        logic [31:0] t;
        t = x ^ (x << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return t;
    endfunction

endpackage

[hw/rtl/rnns_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module rnns_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/rnns_mod_unit.sv]
// Bit-serial restoring remainder unit: 32-bit dividend modulo a 16-bit divisor.
module rnns_mod_unit
    import rnns_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  div_req_t    req,
    output logic        done,
    output logic [15:0] remainder
);

    logic [31:0] dvd_reg;
    logic [31:0] dvd_next;
    logic [15:0] dvs_reg;
    logic [15:0] rem_reg;
    logic [15:0] rem_next;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [16:0] trial;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[31]};
        if (trial >= {1'b0, dvs_reg})
        begin
            rem_next = 16'(trial - {1'b0, dvs_reg});
        end
        else
        begin
            rem_next = trial[15:0];
        end
        dvd_next = {dvd_reg[30:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

[hw/rtl/random_n_of_n_packet_sampler_top.sv]
// A counted packet that triggers no pick generation steps through ST_QUAL, ST_COUNT, ST_CMP
// and ST_FINISH after acceptance; a packet that fails qualification goes from ST_QUAL to ST_FINISH.
// Packets are taken only in ST_IDLE, so a new packet waits until the last one's result is loaded.
// Generating n picks adds, for each pick, a remainder draw in the bit-serial unit and scans of
// the pick table, which has a single read port, plus a fresh draw and scan for each duplicate.
// Reset is asynchronous and active low; it loads n = 1, N = 100 and a generator state of 1.
`include "random_n_of_n_packet_sampler_top_defines.svh"

module random_n_of_n_packet_sampler_top
    import rnns_pkg::*;
#(
    parameter int MAX_PICKS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [15:0]            captured_length,
    input  logic [15:0]            ether_kind,
    input  logic [3:0]             ip_header_words,
    input  logic [7:0]             ip_protocol,
    input  logic [3:0]             tcp_header_words,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   eligible,
    output logic                   sampled,
    output logic [15:0]            window_position,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data
);

    localparam int CW = $clog2(MAX_PICKS + 1);
    localparam int AW = (MAX_PICKS > 1) ? $clog2(MAX_PICKS) : 1;
    localparam logic [15:0] MAX_PICKS16 = 16'(MAX_PICKS);

    state_t state_reg;
    state_t state_next;

    logic [4:0]    ppw_reg;
    logic [15:0]   ws_reg;
    logic [31:0]   rng_reg;
    logic [15:0]   count_reg;
    logic [CW-1:0] idx_reg;
    logic          picks_ready_reg;
    logic          ret_finish_reg;
    logic [CW-1:0] gi_reg;
    logic [CW-1:0] gj_reg;
    logic          out_valid_reg;

    logic [15:0] len_reg;
    logic [15:0] kind_reg;
    logic [3:0]  ihw_reg;
    logic [7:0]  proto_reg;
    logic [3:0]  thw_reg;
    logic [15:0] v_reg;
    logic [15:0] pos_reg;
    logic        res_elig_reg;
    logic        res_samp_reg;
    logic [15:0] res_pos_reg;
    logic        elig_reg;
    logic        samp_reg;
    logic [15:0] wpos_reg;

    logic [15:0]   eff_n16;
    logic [15:0]   picks16;
    logic [CW-1:0] n_eff;
    logic          qual;
    logic          hit;
    logic          out_load;
    logic [CW-1:0] gj_m1;

    logic [15:0] l1;
    logic [15:0] l2;
    logic [15:0] l3;
    logic [15:0] ihl_bytes;
    logic [15:0] thl_bytes;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [15:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [15:0]   ram_rdata;

    div_req_t    div_req;
    logic        div_done;
    logic [15:0] div_rem;

    always_comb
    begin
        eff_n16 = (ws_reg < 16'd2) ? 16'd1 : ws_reg;
        picks16 = {11'd0, ppw_reg};
        if (picks16 > MAX_PICKS16)
        begin
            picks16 = MAX_PICKS16;
        end
        if (picks16 > 16'(eff_n16 - 16'd1))
        begin
            picks16 = 16'(eff_n16 - 16'd1);
        end
        n_eff = picks16[CW-1:0];
    end

    always_comb
    begin
        ihl_bytes = {10'd0, ihw_reg, 2'b00};
        thl_bytes = {10'd0, thw_reg, 2'b00};
        l1 = 16'(len_reg - ETH_HDR_LEN);
        qual = (len_reg >= ETH_HDR_LEN);
        if (kind_reg == ETH_TYPE_VLAN)
        begin
            qual = qual && (l1 >= VLAN_TAG_LEN);
            l2 = 16'(l1 - VLAN_TAG_LEN);
        end
        else
        begin
            qual = qual && ((kind_reg == ETH_TYPE_IPV4) || (kind_reg == ETH_TYPE_ARP));
            l2 = l1;
        end
        qual = qual && (l2 >= 16'd1) && (l2 >= ihl_bytes);
        l3 = 16'(l2 - ihl_bytes);
        if (proto_reg == PROTO_TCP)
        begin
            qual = qual && (l3 >= TCP_MIN_LEN) && (l3 >= thl_bytes);
        end
        else if (proto_reg == PROTO_UDP)
        begin
            qual = qual && (l3 >= UDP_HDR_LEN);
        end
        else if (proto_reg == PROTO_ICMP)
        begin
            qual = qual && (l3 >= ICMP_HDR_LEN);
        end
        else
        begin
            qual = 1'b0;
        end
    end

    assign hit      = (idx_reg < n_eff) && (ram_rdata == pos_reg);
    assign out_load = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);
    assign gj_m1    = gj_reg - 1'b1;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_QUAL;
                end
            end
            ST_QUAL:
            begin
                priority if (!qual)
                begin
                    state_next = ST_FINISH;
                end
                else if (!picks_ready_reg)
                begin
                    state_next = ST_GEN;
                end
                else
                begin
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                state_next = (pos_reg >= eff_n16) ? ST_GEN : ST_FINISH;
            end
            ST_GEN:
            begin
                if (gi_reg == n_eff)
                begin
                    state_next = ret_finish_reg ? ST_FINISH : ST_COUNT;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_DUP_RD;
                end
            end
            ST_DUP_RD:
            begin
                state_next = (gj_reg == gi_reg) ? ST_INS_RD : ST_DUP_CMP;
            end
            ST_DUP_CMP:
            begin
                state_next = (ram_rdata == v_reg) ? ST_GEN : ST_DUP_RD;
            end
            ST_INS_RD:
            begin
                state_next = (gj_reg == '0) ? ST_GEN : ST_INS_CMP;
            end
            ST_INS_CMP:
            begin
                state_next = (ram_rdata > v_reg) ? ST_INS_RD : ST_GEN;
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        cfg_ready = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = gj_reg[AW-1:0];
        ram_wdata = v_reg;
        ram_raddr = '0;
        div_req.start    = 1'b0;
        div_req.dividend = xorshift32(rng_reg);
        div_req.divisor  = eff_n16;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                cfg_ready = 1'b1;
            end
            ST_COUNT:
            begin
                ram_raddr = idx_reg[AW-1:0];
            end
            ST_GEN:
            begin
                div_req.start = (gi_reg != n_eff);
            end
            ST_DUP_RD:
            begin
                ram_raddr = gj_reg[AW-1:0];
            end
            ST_INS_RD:
            begin
                ram_raddr = gj_m1[AW-1:0];
                if (gj_reg == '0)
                begin
                    ram_we = 1'b1;
                end
            end
            ST_INS_CMP:
            begin
                ram_we = 1'b1;
                if (ram_rdata > v_reg)
                begin
                    ram_wdata = ram_rdata;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            ppw_reg         <= 5'd1;
            ws_reg          <= 16'd100;
            rng_reg         <= 32'd1;
            count_reg       <= '0;
            idx_reg         <= '0;
            picks_ready_reg <= 1'b0;
            ret_finish_reg  <= 1'b0;
            gi_reg          <= '0;
            gj_reg          <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_PICKS:  ppw_reg <= cfg_data[4:0];
                    CFG_WINDOW: ws_reg  <= cfg_data[15:0];
                    CFG_SEED:   rng_reg <= (cfg_data == 32'd0) ? 32'd1 : cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            unique case (state_reg)
                ST_QUAL:
                begin
                    if (qual && !picks_ready_reg)
                    begin
                        picks_ready_reg <= 1'b1;
                        ret_finish_reg  <= 1'b0;
                        gi_reg          <= '0;
                    end
                end
                ST_COUNT:
                begin
                    count_reg <= count_reg + 16'd1;
                end
                ST_CMP:
                begin
                    if (hit)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    if (pos_reg >= eff_n16)
                    begin
                        count_reg      <= '0;
                        idx_reg        <= '0;
                        ret_finish_reg <= 1'b1;
                        gi_reg         <= '0;
                    end
                end
                ST_GEN:
                begin
                    if (gi_reg != n_eff)
                    begin
                        rng_reg <= xorshift32(rng_reg);
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        gj_reg <= '0;
                    end
                end
                ST_DUP_CMP:
                begin
                    if (ram_rdata != v_reg)
                    begin
                        gj_reg <= gj_reg + 1'b1;
                    end
                end
                ST_INS_RD:
                begin
                    if (gj_reg == '0)
                    begin
                        gi_reg <= gi_reg + 1'b1;
                    end
                end
                ST_INS_CMP:
                begin
                    if (ram_rdata > v_reg)
                    begin
                        gj_reg <= gj_m1;
                    end
                    else
                    begin
                        gi_reg <= gi_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            len_reg   <= captured_length;
            kind_reg  <= ether_kind;
            ihw_reg   <= ip_header_words;
            proto_reg <= ip_protocol;
            thw_reg   <= tcp_header_words;
        end
        if ((state_reg == ST_DIV) && div_done)
        begin
            v_reg <= div_rem + 16'd1;
        end
        if (state_reg == ST_COUNT)
        begin
            pos_reg <= count_reg + 16'd1;
        end
        if ((state_reg == ST_QUAL) && !qual)
        begin
            res_elig_reg <= 1'b0;
            res_samp_reg <= 1'b0;
            res_pos_reg  <= '0;
        end
        if (state_reg == ST_CMP)
        begin
            res_elig_reg <= 1'b1;
            res_samp_reg <= hit;
            res_pos_reg  <= pos_reg;
        end
        if (out_load)
        begin
            elig_reg <= res_elig_reg;
            samp_reg <= res_samp_reg;
            wpos_reg <= res_pos_reg;
        end
    end

    rnns_ram #(
        .WIDTH (16),
        .DEPTH (MAX_PICKS),
        .AW    (AW)
    ) u_pick_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rnns_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .done      (div_done),
        .remainder (div_rem)
    );

    assign out_valid       = out_valid_reg;
    assign eligible        = elig_reg;
    assign sampled         = samp_reg;
    assign window_position = wpos_reg;

    `RNNS_ASSERT_SAME(a_sampled_eligible, clk, rst_n, out_valid && sampled, eligible)
    `RNNS_ASSERT_SAME(a_position_eligible, clk, rst_n, out_valid,
        eligible == (window_position != 16'd0))
    `RNNS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule
